FILE: hdl/tqi_pkg.sv
package tqi_pkg;

   localparam int TABLE_POINTS_DEFAULT = 20;
   localparam int INIT_POINTS = 20;
   localparam int CMD_ADDR_W = 6;
   localparam int PROD_W = 70;
   localparam int OPND_W = 51;
   localparam int QUO_W = 17;
   localparam int DIV_STEPS = 17;
   localparam int PROG_STEPS = 19;

   localparam logic [3:0] DP_NONE     = 4'd0;
   localparam logic [3:0] DP_LOAD     = 4'd1;
   localparam logic [3:0] DP_MUL      = 4'd2;
   localparam logic [3:0] DP_SAVE_DEN = 4'd3;
   localparam logic [3:0] DP_ACC_ADD  = 4'd4;
   localparam logic [3:0] DP_DIV_INIT = 4'd5;
   localparam logic [3:0] DP_DIV_STEP = 4'd6;

   localparam logic [3:0] SEL_D12  = 4'd0;
   localparam logic [3:0] SEL_D13  = 4'd1;
   localparam logic [3:0] SEL_D23  = 4'd2;
   localparam logic [3:0] SEL_ND13 = 4'd3;
   localparam logic [3:0] SEL_Y1   = 4'd4;
   localparam logic [3:0] SEL_Y2   = 4'd5;
   localparam logic [3:0] SEL_Y3   = 4'd6;
   localparam logic [3:0] SEL_QX1  = 4'd7;
   localparam logic [3:0] SEL_QX2  = 4'd8;
   localparam logic [3:0] SEL_QX3  = 4'd9;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_DEN = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   localparam logic OP_WRITE = 1'b0;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] sel;
   } step_type;

   typedef struct packed {
      logic                  ld_item;
      logic                  mem_we;
      logic [CMD_ADDR_W-1:0] rd_addr;
      logic                  cap_en;
      logic [1:0]            cap_slot;
      logic [3:0]            dp_op;
      logic [3:0]            sel;
      logic                  res_load;
      logic [4:0]            seg;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic q_lt;
   } sts_type;

   function automatic step_type prog_step(input logic [4:0] s);
      step_type r;
      case (s)
         5'd0:  r = '{DP_LOAD, SEL_D12};
         5'd1:  r = '{DP_MUL, SEL_D13};
         5'd2:  r = '{DP_MUL, SEL_D23};
         5'd3:  r = '{DP_SAVE_DEN, SEL_D12};
         5'd4:  r = '{DP_LOAD, SEL_Y1};
         5'd5:  r = '{DP_MUL, SEL_QX2};
         5'd6:  r = '{DP_MUL, SEL_QX3};
         5'd7:  r = '{DP_MUL, SEL_D23};
         5'd8:  r = '{DP_ACC_ADD, SEL_D12};
         5'd9:  r = '{DP_LOAD, SEL_Y2};
         5'd10: r = '{DP_MUL, SEL_QX1};
         5'd11: r = '{DP_MUL, SEL_QX3};
         5'd12: r = '{DP_MUL, SEL_ND13};
         5'd13: r = '{DP_ACC_ADD, SEL_D12};
         5'd14: r = '{DP_LOAD, SEL_Y3};
         5'd15: r = '{DP_MUL, SEL_QX1};
         5'd16: r = '{DP_MUL, SEL_QX2};
         5'd17: r = '{DP_MUL, SEL_D12};
         5'd18: r = '{DP_ACC_ADD, SEL_D12};
         default: r = '{DP_NONE, SEL_D12};
      endcase
      return r;
   endfunction

   function automatic logic [15:0] init_x(input logic [CMD_ADDR_W-1:0] i);
      logic [15:0] r;
      case (i)
         6'd0:  r = 16'd338;
         6'd1:  r = 16'd605;
         6'd2:  r = 16'd1050;
         6'd3:  r = 16'd1493;
         6'd4:  r = 16'd1938;
         6'd5:  r = 16'd2382;
         6'd6:  r = 16'd2827;
         6'd7:  r = 16'd3270;
         6'd8:  r = 16'd3715;
         6'd9:  r = 16'd4160;
         6'd10: r = 16'd4605;
         6'd11: r = 16'd5050;
         6'd12: r = 16'd5493;
         6'd13: r = 16'd5938;
         6'd14: r = 16'd6382;
         6'd15: r = 16'd6827;
         6'd16: r = 16'd7270;
         6'd17: r = 16'd7715;
         6'd18: r = 16'd8160;
         6'd19: r = 16'd8605;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] init_y(input logic [CMD_ADDR_W-1:0] i);
      logic [15:0] r;
      case (i)
         6'd0:  r = 16'd8233;
         6'd1:  r = 16'd8356;
         6'd2:  r = 16'd8561;
         6'd3:  r = 16'd8684;
         6'd4:  r = 16'd8806;
         6'd5:  r = 16'd8847;
         6'd6:  r = 16'd8847;
         6'd7:  r = 16'd8847;
         6'd8:  r = 16'd8847;
         6'd9:  r = 16'd8765;
         6'd10: r = 16'd8684;
         6'd11: r = 16'd8602;
         6'd12: r = 16'd8479;
         6'd13: r = 16'd8356;
         6'd14: r = 16'd8274;
         6'd15: r = 16'd8151;
         6'd16: r = 16'd7987;
         6'd17: r = 16'd7864;
         6'd18: r = 16'd7741;
         6'd19: r = 16'd7619;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/tqi_datapath.sv
module tqi_datapath #(
   parameter int TABLE_POINTS = tqi_pkg::TABLE_POINTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_operation,
   input  logic [4:0]          in_point_index,
   input  logic [15:0]         in_point_x,
   input  logic signed [15:0]  in_point_y,
   input  logic [15:0]         in_query_x,
   input  tqi_pkg::cmd_type    cmd,
   output tqi_pkg::sts_type    sts,
   output logic signed [15:0]  value_y,
   output logic [1:0]          status,
   output logic [4:0]          segment_end
);

   localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
   localparam int PW = tqi_pkg::PROD_W;
   localparam int OW = tqi_pkg::OPND_W;
   localparam int QW = tqi_pkg::QUO_W;

   logic        op_ff;
   logic [4:0]  idx_ff;
   logic [15:0] px_ff, py_ff, qx_ff;

   logic [15:0] mem_x [TABLE_POINTS];
   logic [15:0] mem_y [TABLE_POINTS];
   logic [TABLE_POINTS-1:0] valid_ff;
   logic [15:0] rdm_x_ff, rdm_y_ff, rdi_x_ff, rdi_y_ff;
   logic        rd_vld_ff;
   logic [15:0] rd_x, rd_y;
   logic [AW-1:0] rd_a, wr_a;
   logic        wr_ok;

   logic [15:0] x_ff [3];
   logic [15:0] y_ff [3];

   logic signed [16:0] d12, d13, d23, opnd;
   logic signed [16:0] qx1, qx2, qx3;
   logic signed [PW-1:0] prod_ff, num_ff;
   logic signed [OW-1:0] den_ff;
   logic signed [PW-3:0] mul;
   logic [PW-1:0] num_mag, sat_pos, sat_neg;
   logic [OW-1:0] dm_ff, den_mag;
   logic [OW-1:0] rem_ff;
   logic [OW:0]   rem_sh, rem_sub;
   logic [QW-1:0] quo_ff;
   logic          neg_ff, sat_ff, den_zero;

   logic signed [15:0] val_ff;
   logic [1:0]         st_ff;
   logic [4:0]         seg_ff;
   logic signed [15:0] val_in;
   logic [1:0]         st_in;

   always_ff @(posedge clock) begin
      if (cmd.ld_item) begin
         op_ff  <= in_operation;
         idx_ff <= in_point_index;
         px_ff  <= in_point_x;
         py_ff  <= in_point_y;
         qx_ff  <= in_query_x;
      end
   end

   assign wr_a  = AW'(idx_ff);
   assign wr_ok = ({1'b0, idx_ff} < 6'(TABLE_POINTS)) || (TABLE_POINTS > 31);
   assign rd_a  = AW'(cmd.rd_addr);

   always_ff @(posedge clock) begin
      if (cmd.mem_we && wr_ok) begin
         mem_x[wr_a] <= px_ff;
         mem_y[wr_a] <= py_ff;
      end
      rdm_x_ff <= mem_x[rd_a];
      rdm_y_ff <= mem_y[rd_a];
      rdi_x_ff <= tqi_pkg::init_x(cmd.rd_addr);
      rdi_y_ff <= tqi_pkg::init_y(cmd.rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.mem_we && wr_ok) begin
            valid_ff[wr_a] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_a];
      end
   end

   assign rd_x = rd_vld_ff ? rdm_x_ff : rdi_x_ff;
   assign rd_y = rd_vld_ff ? rdm_y_ff : rdi_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         x_ff[cmd.cap_slot] <= rd_x;
         y_ff[cmd.cap_slot] <= rd_y;
      end
   end

   assign d12 = $signed({1'b0, x_ff[0]}) - $signed({1'b0, x_ff[1]});
   assign d13 = $signed({1'b0, x_ff[0]}) - $signed({1'b0, x_ff[2]});
   assign d23 = $signed({1'b0, x_ff[1]}) - $signed({1'b0, x_ff[2]});
   assign qx1 = $signed({1'b0, qx_ff}) - $signed({1'b0, x_ff[0]});
   assign qx2 = $signed({1'b0, qx_ff}) - $signed({1'b0, x_ff[1]});
   assign qx3 = $signed({1'b0, qx_ff}) - $signed({1'b0, x_ff[2]});

   always_comb begin
      case (cmd.sel)
         tqi_pkg::SEL_D12:  opnd = d12;
         tqi_pkg::SEL_D13:  opnd = d13;
         tqi_pkg::SEL_D23:  opnd = d23;
         tqi_pkg::SEL_ND13: opnd = -d13;
         tqi_pkg::SEL_Y1:   opnd = {y_ff[0][15], y_ff[0]};
         tqi_pkg::SEL_Y2:   opnd = {y_ff[1][15], y_ff[1]};
         tqi_pkg::SEL_Y3:   opnd = {y_ff[2][15], y_ff[2]};
         tqi_pkg::SEL_QX1:  opnd = qx1;
         tqi_pkg::SEL_QX2:  opnd = qx2;
         tqi_pkg::SEL_QX3:  opnd = qx3;
         default:           opnd = d12;
      endcase
   end

   assign mul     = $signed(prod_ff[OW-1:0]) * opnd;
   assign num_mag = num_ff[PW-1] ? PW'(-num_ff) : PW'(num_ff);
   assign den_mag = den_ff[OW-1] ? OW'(-den_ff) : OW'(den_ff);
   assign sat_pos = {{(PW-OW){1'b0}}, den_mag} << 15;
   assign sat_neg = sat_pos + {{(PW-OW){1'b0}}, den_mag};
   assign rem_sh  = {rem_ff, quo_ff[QW-1]};
   assign rem_sub = rem_sh - {1'b0, dm_ff};
   assign den_zero = (den_ff == '0);

   always_ff @(posedge clock) begin
      case (cmd.dp_op)
         tqi_pkg::DP_LOAD: begin
            prod_ff <= PW'(opnd);
         end
         tqi_pkg::DP_MUL: begin
            prod_ff <= {{2{mul[PW-3]}}, mul};
         end
         tqi_pkg::DP_SAVE_DEN: begin
            den_ff <= prod_ff[OW-1:0];
            num_ff <= '0;
         end
         tqi_pkg::DP_ACC_ADD: begin
            num_ff <= num_ff + prod_ff;
         end
         tqi_pkg::DP_DIV_INIT: begin
            dm_ff  <= den_mag;
            neg_ff <= num_ff[PW-1] ^ den_ff[OW-1];
            sat_ff <= (num_ff[PW-1] ^ den_ff[OW-1]) ? (num_mag >= sat_neg)
                                                     : (num_mag >= sat_pos);
            rem_ff <= num_mag[QW +: OW];
            quo_ff <= num_mag[QW-1:0];
         end
         tqi_pkg::DP_DIV_STEP: begin
            if (rem_sh >= {1'b0, dm_ff}) begin
               rem_ff <= rem_sub[OW-1:0];
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[OW-1:0];
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (op_ff == tqi_pkg::OP_WRITE) begin
         val_in = '0;
         st_in  = tqi_pkg::STATUS_OK;
      end else if (den_zero) begin
         val_in = '0;
         st_in  = tqi_pkg::STATUS_DEN;
      end else if (sat_ff) begin
         val_in = neg_ff ? 16'sh8000 : 16'sh7FFF;
         st_in  = tqi_pkg::STATUS_SAT;
      end else begin
         val_in = neg_ff ? 16'(-quo_ff) : quo_ff[15:0];
         st_in  = tqi_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         val_ff <= val_in;
         st_ff  <= st_in;
         seg_ff <= (op_ff == tqi_pkg::OP_WRITE) ? 5'd2 : cmd.seg;
      end
   end

   assign sts.is_write = (op_ff == tqi_pkg::OP_WRITE);
   assign sts.q_lt     = (qx_ff < rd_x);
   assign value_y      = val_ff;
   assign status       = st_ff;
   assign segment_end  = seg_ff;

endmodule

FILE: hdl/tqi_controller.sv
module tqi_controller #(
   parameter int TABLE_POINTS = tqi_pkg::TABLE_POINTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_we,
   input  logic [4:0]       csr_wdata,
   input  tqi_pkg::sts_type sts,
   output tqi_pkg::cmd_type cmd
);

   localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
   localparam int CW = $clog2(TABLE_POINTS + 1);
   localparam int NW = tqi_pkg::CMD_ADDR_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DISP   = 3'd1;
   localparam logic [2:0] S_SRCH   = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_CALC   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [4:0]    piu_ff;
   logic [AW-1:0] i_ff, i_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] n_val;
   tqi_pkg::step_type stp;
   logic          last_pt;

   always_comb begin
      if (int'(piu_ff) < 3) begin
         n_val = CW'(3);
      end else if (int'(piu_ff) > TABLE_POINTS) begin
         n_val = CW'(TABLE_POINTS);
      end else begin
         n_val = CW'(piu_ff);
      end
   end

   assign last_pt = (CW'(i_ff) == n_val - CW'(1));
   assign stp     = tqi_pkg::prog_step(cnt_ff);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.seg      = 5'(i_ff);
      req_tready   = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.ld_item = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.is_write) begin
               cmd.mem_we = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_addr = NW'(2);
               i_in        = AW'(2);
               state_in    = S_SRCH;
            end
         end
         S_SRCH: begin
            cmd.rd_addr = NW'(i_ff + AW'(1));
            if (sts.q_lt || last_pt) begin
               cnt_in   = '0;
               state_in = S_LOAD;
            end else begin
               i_in = i_ff + AW'(1);
            end
         end
         S_LOAD: begin
            cmd.rd_addr  = NW'(i_ff - AW'(2) + AW'(cnt_ff));
            cmd.cap_en   = (cnt_ff != 5'd0);
            cmd.cap_slot = 2'(cnt_ff - 5'd1);
            if (cnt_ff == 5'd3) begin
               cnt_in   = '0;
               state_in = S_CALC;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_CALC: begin
            cmd.dp_op = stp.op;
            cmd.sel   = stp.sel;
            if (cnt_ff == 5'(tqi_pkg::PROG_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIV: begin
            if (cnt_ff == 5'd0) begin
               cmd.dp_op = tqi_pkg::DP_DIV_INIT;
            end else begin
               cmd.dp_op = tqi_pkg::DP_DIV_STEP;
            end
            if (cnt_ff == 5'(tqi_pkg::DIV_STEPS)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         piu_ff       <= 5'd20;
         i_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         cnt_ff       <= cnt_in;
         if (csr_we) begin
            piu_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_srch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (i_ff >= AW'(2)) && (CW'(i_ff) < n_val))
      else $error("search index out of range");
   a_load_no_clobber: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten");
   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_item |=> (state_ff == S_DISP))
      else $error("accepted beat not dispatched");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= 5'(tqi_pkg::DIV_STEPS)))
      else $error("division step count overrun");
`endif

endmodule

FILE: hdl/table_quadratic_interpolator_unit.sv
// Piecewise quadratic interpolator over a calibration table of TABLE_POINTS
// points (x unsigned Q12.4, y signed Q4.12), reset to twenty built-in points.
// A req beat with tuser 0 rewrites one point (if point_index is below
// TABLE_POINTS) and answers value 0, status 0, segment 2; with tuser 1 it
// interpolates at query_x: a search walks the table one point per cycle
// from index 2, the three points are fetched from the single read port, a
// shared 51x17 multiplier runs a 19-step program, and a serial divider
// forms the quotient; the result is loaded into the rsp register once it
// is free, and the next beat is taken in the cycle after that. One beat is
// in work at a time; a finished result waits in the rsp register while the
// next beat is taken. Write points_in_use (csr) only while idle.
module table_quadratic_interpolator_unit #(
   parameter int TABLE_POINTS = tqi_pkg::TABLE_POINTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_index[4:0], point_x[20:5], point_y[36:21], query_x[52:37]
   input  logic [55:0] req_tdata,
   // operation[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value_y[15:0], status[17:16], segment_end[22:18]
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   tqi_pkg::cmd_type cmd;
   tqi_pkg::sts_type sts;
   logic signed [15:0] value_y;
   logic [1:0]         status;
   logic [4:0]         segment_end;

   tqi_controller #(.TABLE_POINTS(TABLE_POINTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .sts        (sts),
      .cmd        (cmd)
   );

   tqi_datapath #(.TABLE_POINTS(TABLE_POINTS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .in_operation   (req_tuser),
      .in_point_index (req_tdata[4:0]),
      .in_point_x     (req_tdata[20:5]),
      .in_point_y     (req_tdata[36:21]),
      .in_query_x     (req_tdata[52:37]),
      .cmd            (cmd),
      .sts            (sts),
      .value_y        (value_y),
      .status         (status),
      .segment_end    (segment_end)
   );

   assign rsp_tdata = {1'b0, segment_end, status, value_y};

endmodule
